// File: hdl/ttab_pkg.sv
// Shared types, constants and helpers for the timer table engine.
`timescale 1ns / 1ps
package ttab_pkg;

	localparam int TIMER_SLOTS  = 16;
	localparam int EXPIRE_BATCH = 8;
	localparam int SLOT_IW      = $clog2(TIMER_SLOTS);
	localparam int CNT_W        = $clog2(TIMER_SLOTS + 1);
	localparam int RUN_CAP      = (EXPIRE_BATCH < TIMER_SLOTS) ? EXPIRE_BATCH : TIMER_SLOTS;
	localparam int PADDR_W      = 3;
	localparam logic [30:0] EMPTY_WAIT_RST = 31'd1000;
	localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [30:0] WAIT_MAX = 31'h7FFF_FFFF;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_CLEAR    = 3'd1,
		CMD_RUN      = 3'd2,
		CMD_NEAREST  = 3'd3,
		CMD_STOP_ALL = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		EV_ADDED      = 3'd0,
		EV_ADD_FAIL   = 3'd1,
		EV_FIRED_PER  = 3'd2,
		EV_FIRED_FIN  = 3'd3,
		EV_STOPPED    = 3'd4,
		EV_CLEAR_MISS = 3'd5,
		EV_NEAREST    = 3'd6,
		EV_DONE       = 3'd7
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_ADD,
		ST_CLEAR,
		ST_SCAN_START,
		ST_SCAN,
		ST_SCAN_WAIT,
		ST_DECIDE,
		ST_FIRE_RD,
		ST_FIRE,
		ST_STOP,
		ST_NEAR,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCAN_START,
		OP_SCAN,
		OP_READ_BEST,
		OP_ADD,
		OP_CLEAR,
		OP_FIRE,
		OP_STOP,
		OP_NEAR,
		OP_DONE
	} op_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       best_valid;
		logic       scan_last;
		logic       cnt_last;
		logic       out_free;
	} dp_status_t;

	function automatic logic [47:0] sat48(input logic [47:0] a, input logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

endpackage

// File: hdl/timer_table_engine.sv
// Top level of the timer table engine.
// Add, clear and unknown commands: dispatch, then one registered result with last set.
// Nearest: one sweep; each sweep reads one slot a cycle from the table.
// Run: up to min(EXPIRE_BATCH, TIMER_SLOTS) rounds of one sweep and one firing, then done.
// Stop all: one round per armed timer plus a final sweep; one request at a time.
// Reset clears all timers and sets empty_wait to 1000; table contents stay unset until added.
`timescale 1ns / 1ps
module timer_table_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ttab_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [2:0]                   command,
	input  logic [47:0]                  now,
	input  logic [31:0]                  timeout,
	input  logic [31:0]                  repeat_req,
	input  logic [3:0]                   slot,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [2:0]                   event_kind,
	output logic [3:0]                   timer_slot,
	output logic [30:0]                  value,
	output logic                         last
);
	import ttab_pkg::*;

	logic [30:0] empty_wait;
	op_t         op;
	dp_status_t  status;

	ttab_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.empty_wait (empty_wait)
	);

	ttab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.op       (op)
	);

	ttab_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.status     (status),
		.empty_wait (empty_wait),
		.command    (command),
		.now        (now),
		.timeout    (timeout),
		.repeat_req (repeat_req),
		.slot       (slot),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.timer_slot (timer_slot),
		.value      (value),
		.last       (last)
	);

endmodule

// File: hdl/ttab_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ttab_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ttab_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [30:0]                 empty_wait
);
	import ttab_pkg::*;

	logic [30:0] empty_wait_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_wait_q <= EMPTY_WAIT_RST;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			empty_wait_q <= pwdata[30:0];
		end
	end

	assign pready     = 1'b1;
	assign prdata     = paddr[2] ? 32'd0 : {1'b0, empty_wait_q};
	assign empty_wait = empty_wait_q;

endmodule

// File: hdl/ttab_ctrl.sv
// Command sequencer: sweeps, firing rounds and result emission order.
`timescale 1ns / 1ps
module ttab_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ttab_pkg::dp_status_t status,
	output ttab_pkg::op_t        op
);
	import ttab_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				priority case (status.cmd)
					CMD_ADD:      state_nx = ST_ADD;
					CMD_CLEAR:    state_nx = ST_CLEAR;
					CMD_RUN,
					CMD_NEAREST,
					CMD_STOP_ALL: state_nx = ST_SCAN_START;
					default:      state_nx = ST_DONE;
				endcase
			end
			ST_ADD, ST_CLEAR, ST_NEAR, ST_DONE: begin
				if (status.out_free) state_nx = ST_IDLE;
			end
			ST_SCAN_START: state_nx = ST_SCAN;
			ST_SCAN: begin
				if (status.scan_last) state_nx = ST_SCAN_WAIT;
			end
			ST_SCAN_WAIT: state_nx = ST_DECIDE;
			ST_DECIDE: begin
				priority if (status.cmd == CMD_NEAREST) state_nx = ST_NEAR;
				else if (!status.best_valid)        state_nx = ST_DONE;
				else if (status.cmd == CMD_RUN)     state_nx = ST_FIRE_RD;
				else                                state_nx = ST_STOP;
			end
			ST_FIRE_RD: state_nx = ST_FIRE;
			ST_FIRE: begin
				if (status.out_free) state_nx = status.cnt_last ? ST_DONE : ST_SCAN_START;
			end
			ST_STOP: begin
				if (status.out_free) state_nx = ST_SCAN_START;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) op = OP_LOAD;
			end
			ST_ADD:        if (status.out_free) op = OP_ADD;
			ST_CLEAR:      if (status.out_free) op = OP_CLEAR;
			ST_NEAR:       if (status.out_free) op = OP_NEAR;
			ST_DONE:       if (status.out_free) op = OP_DONE;
			ST_FIRE:       if (status.out_free) op = OP_FIRE;
			ST_STOP:       if (status.out_free) op = OP_STOP;
			ST_SCAN_START: op = OP_SCAN_START;
			ST_SCAN:       op = OP_SCAN;
			ST_FIRE_RD:    op = OP_READ_BEST;
			default:       op = OP_NONE;
		endcase
	end

endmodule

// File: hdl/ttab_dp.sv
// Datapath: slot table, sweep compare, deadline arithmetic and result register.
`timescale 1ns / 1ps
module ttab_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ttab_pkg::op_t         op,
	output ttab_pkg::dp_status_t  status,
	input  logic [30:0]           empty_wait,
	input  logic [2:0]            command,
	input  logic [47:0]           now,
	input  logic [31:0]           timeout,
	input  logic [31:0]           repeat_req,
	input  logic [3:0]            slot,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            event_kind,
	output logic [3:0]            timer_slot,
	output logic [30:0]           value,
	output logic                  last
);
	import ttab_pkg::*;

	logic [2:0]  cmd_q;
	logic [47:0] now_q;
	logic [31:0] tmo_q;
	logic [31:0] rep_q;
	logic [3:0]  slot_q;

	logic [TIMER_SLOTS-1:0] armed_q;
	logic [TIMER_SLOTS-1:0] skip_q;
	logic [47:0] dl_mem [TIMER_SLOTS];
	logic [31:0] iv_mem [TIMER_SLOTS];
	logic [47:0] rd_dl_q;
	logic [31:0] rd_iv_q;

	logic [SLOT_IW-1:0] idx_q;
	logic [SLOT_IW-1:0] tag_s1;
	logic               tag_v_s1;
	logic               best_v_q;
	logic [SLOT_IW-1:0] best_slot_q;
	logic [47:0]        best_dl_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               out_valid_q;
	logic [2:0]         kind_q;
	logic [3:0]         oslot_q;
	logic [30:0]        value_q;
	logic               last_q;

	logic               out_free;
	logic               free_found;
	logic [SLOT_IW-1:0] free_idx;
	logic [SLOT_IW-1:0] clr_idx;
	logic               clr_hit;
	logic [47:0]        limit;
	logic               cand;
	logic               rd_en;
	logic [SLOT_IW-1:0] rd_addr;
	logic               dl_we;
	logic               iv_we;
	logic [SLOT_IW-1:0] wr_addr;
	logic [47:0]        dl_wd;
	logic [47:0]        diff;
	logic [30:0]        wait_v;
	logic               periodic;

	assign out_free = !out_valid_q || !out_stall;
	assign clr_idx  = SLOT_IW'(slot_q);
	assign clr_hit  = (32'(slot_q) < TIMER_SLOTS) && armed_q[clr_idx];
	assign limit    = (cmd_q == CMD_RUN) ? now_q : TIME_MAX;
	assign periodic = (rd_iv_q != 32'd0);

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!armed_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_IW'(i);
			end
		end
	end

	assign cand = tag_v_s1 && armed_q[tag_s1] && !skip_q[tag_s1] && (rd_dl_q <= limit)
		&& (!best_v_q || (rd_dl_q < best_dl_q));

	always_comb begin
		diff = best_dl_q - now_q;
		if (best_dl_q <= now_q) begin
			wait_v = 31'd0;
		end else if (diff > {17'd0, WAIT_MAX}) begin
			wait_v = WAIT_MAX;
		end else begin
			wait_v = diff[30:0];
		end
	end

	assign rd_en   = (op == OP_SCAN) || (op == OP_READ_BEST);
	assign rd_addr = (op == OP_READ_BEST) ? best_slot_q : idx_q;
	assign dl_we   = ((op == OP_ADD) && free_found) || ((op == OP_FIRE) && periodic);
	assign iv_we   = (op == OP_ADD) && free_found;
	assign wr_addr = (op == OP_ADD) ? free_idx : best_slot_q;
	assign dl_wd   = (op == OP_ADD) ? sat48(now_q, tmo_q) : sat48(best_dl_q, rd_iv_q);

	always_ff @(posedge clk) begin
		if (dl_we) dl_mem[wr_addr] <= dl_wd;
		if (iv_we) iv_mem[wr_addr] <= rep_q;
		if (rd_en) begin
			rd_dl_q <= dl_mem[rd_addr];
			rd_iv_q <= iv_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			cmd_q  <= command;
			now_q  <= now;
			tmo_q  <= timeout;
			rep_q  <= repeat_req;
			slot_q <= slot;
		end
		if (op == OP_SCAN) tag_s1 <= idx_q;
		if (cand) begin
			best_slot_q <= tag_s1;
			best_dl_q   <= rd_dl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= '0;
			skip_q   <= '0;
			idx_q    <= '0;
			tag_v_s1 <= 1'b0;
			best_v_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			tag_v_s1 <= (op == OP_SCAN);
			if (cand) best_v_q <= 1'b1;
			unique case (op)
				OP_LOAD: begin
					skip_q <= '0;
					cnt_q  <= '0;
				end
				OP_SCAN_START: begin
					idx_q    <= '0;
					best_v_q <= 1'b0;
				end
				OP_SCAN: idx_q <= idx_q + 1'b1;
				OP_ADD: begin
					if (free_found) armed_q[free_idx] <= 1'b1;
				end
				OP_CLEAR: begin
					if (clr_hit) armed_q[clr_idx] <= 1'b0;
				end
				OP_FIRE: begin
					skip_q[best_slot_q] <= 1'b1;
					if (!periodic) armed_q[best_slot_q] <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
				end
				OP_STOP: begin
					armed_q[best_slot_q] <= 1'b0;
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_ADD, OP_CLEAR, OP_FIRE, OP_STOP, OP_NEAR, OP_DONE: out_valid_q <= 1'b1;
				default: if (!out_stall) out_valid_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_ADD: begin
				kind_q  <= free_found ? EV_ADDED : EV_ADD_FAIL;
				oslot_q <= free_found ? 4'(free_idx) : 4'd0;
				value_q <= '0;
				last_q  <= 1'b1;
			end
			OP_CLEAR: begin
				kind_q  <= clr_hit ? EV_STOPPED : EV_CLEAR_MISS;
				oslot_q <= slot_q;
				value_q <= '0;
				last_q  <= 1'b1;
			end
			OP_FIRE: begin
				kind_q  <= periodic ? EV_FIRED_PER : EV_FIRED_FIN;
				oslot_q <= 4'(best_slot_q);
				value_q <= '0;
				last_q  <= 1'b0;
			end
			OP_STOP: begin
				kind_q  <= EV_STOPPED;
				oslot_q <= 4'(best_slot_q);
				value_q <= '0;
				last_q  <= 1'b0;
			end
			OP_NEAR: begin
				kind_q  <= EV_NEAREST;
				oslot_q <= best_v_q ? 4'(best_slot_q) : 4'd0;
				value_q <= best_v_q ? wait_v : empty_wait;
				last_q  <= 1'b1;
			end
			OP_DONE: begin
				kind_q  <= EV_DONE;
				oslot_q <= 4'd0;
				value_q <= 31'(cnt_q);
				last_q  <= 1'b1;
			end
			default: ;
		endcase
	end

	assign status.cmd        = cmd_q;
	assign status.best_valid = best_v_q;
	assign status.scan_last  = (idx_q == SLOT_IW'(TIMER_SLOTS - 1));
	assign status.cnt_last   = (cnt_q == CNT_W'(RUN_CAP - 1));
	assign status.out_free   = out_free;

	assign out_valid  = out_valid_q;
	assign event_kind = kind_q;
	assign timer_slot = oslot_q;
	assign value      = value_q;
	assign last       = last_q;

endmodule

// File: hdl/ttab_checker.sv
// Port-level checks for the timer table engine, bound to the top level.
`timescale 1ns / 1ps
module ttab_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  event_kind,
	input logic [3:0]  timer_slot,
	input logic [30:0] value,
	input logic        last
);
	import ttab_pkg::*;

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("request taken while previous one still in flight");

	a_open_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> in_stall)
		else $error("new request allowed before final result");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_kind == EV_ADDED || event_kind == EV_ADD_FAIL
			|| event_kind == EV_CLEAR_MISS || event_kind == EV_NEAREST
			|| event_kind == EV_DONE)) |-> last)
		else $error("single-result kind without last");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_kind)
			&& $stable(timer_slot) && $stable(value) && $stable(last)))
		else $error("stalled result changed");

endmodule

bind timer_table_engine ttab_checker u_ttab_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_kind (event_kind),
	.timer_slot (timer_slot),
	.value      (value),
	.last       (last)
);

// File: sim/tb_timer_table_engine.sv
// Self-checking testbench for the timer table engine: directed table, then random commands.
`timescale 1ns / 1ps
module tb_timer_table_engine;
	import ttab_pkg::*;

	typedef struct {
		logic [2:0]  cmd;
		logic [47:0] tnow;
		logic [31:0] tmo;
		logic [31:0] rep;
		logic [3:0]  sl;
		bit          typed;
		logic [2:0]  xkind;
		logic [30:0] xvalue;
	} row_t;

	typedef struct {
		logic [2:0]  kind;
		logic [3:0]  tslot;
		logic [30:0] val;
		logic        lst;
	} event_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] command = '0;
	logic [47:0] now = '0;
	logic [31:0] timeout = '0;
	logic [31:0] repeat_req = '0;
	logic [3:0] slot = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] event_kind;
	logic [3:0] timer_slot;
	logic [30:0] value;
	logic last;

	bit          armed [TIMER_SLOTS];
	logic [47:0] deadline [TIMER_SLOTS];
	logic [31:0] interval [TIMER_SLOTS];
	logic [30:0] empty_wait_m = EMPTY_WAIT_RST;

	event_t pending_events[$];
	int mismatches = 0;
	int events_seen = 0;
	int requests_sent = 0;
	int cycles = 0;
	bit calm = 0;
	bit timed_out = 0;
	logic [47:0] clock_ms = '0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	timer_table_engine dut (.*);

	function automatic int earliest_slot(bit skip[TIMER_SLOTS], logic [47:0] limit);
		int best;
		best = -1;
		for (int i = 0; i < TIMER_SLOTS; i++)
			if (armed[i] && !skip[i] && deadline[i] <= limit)
				if (best < 0 || deadline[i] < deadline[best])
					best = i;
		return best;
	endfunction

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {17'b0, b};
		return s[48] ? TIME_MAX : s[47:0];
	endfunction

	task automatic push_event(kind_t k, int s, logic [30:0] v);
		event_t e;
		e.kind = k;
		e.tslot = s[3:0];
		e.val = v;
		e.lst = 0;
		pending_events.push_back(e);
	endtask

	task automatic predict_timers(logic [2:0] cmd, logic [47:0] t, logic [31:0] tmo,
			logic [31:0] rep, logic [3:0] sl);
		bit skip[TIMER_SLOTS];
		int picks[$];
		int s;
		int cnt;
		logic [47:0] w;
		cnt = 0;
		s = -1;
		foreach (skip[i]) skip[i] = 0;
		case (cmd)
		CMD_ADD: begin
			for (int i = 0; i < TIMER_SLOTS; i++)
				if (!armed[i] && s < 0) s = i;
			if (s < 0) push_event(EV_ADD_FAIL, 0, 0);
			else begin
				armed[s] = 1;
				deadline[s] = add_sat(t, tmo);
				interval[s] = rep;
				push_event(EV_ADDED, s, 0);
			end
		end
		CMD_CLEAR: begin
			if (armed[sl]) begin
				armed[sl] = 0;
				push_event(EV_STOPPED, sl, 0);
			end else push_event(EV_CLEAR_MISS, sl, 0);
		end
		CMD_RUN: begin
			while (picks.size() < RUN_CAP) begin
				s = earliest_slot(skip, t);
				if (s < 0) break;
				skip[s] = 1;
				picks.push_back(s);
			end
			foreach (picks[i]) begin
				s = picks[i];
				if (interval[s] == 0) begin
					armed[s] = 0;
					push_event(EV_FIRED_FIN, s, 0);
				end else begin
					deadline[s] = add_sat(deadline[s], interval[s]);
					push_event(EV_FIRED_PER, s, 0);
				end
			end
			push_event(EV_DONE, 0, 31'(picks.size()));
		end
		CMD_NEAREST: begin
			s = earliest_slot(skip, TIME_MAX);
			if (s < 0) push_event(EV_NEAREST, 0, empty_wait_m);
			else begin
				w = deadline[s] > t ? deadline[s] - t : 48'd0;
				push_event(EV_NEAREST, s, w > {17'b0, WAIT_MAX} ? WAIT_MAX : w[30:0]);
			end
		end
		CMD_STOP_ALL: begin
			forever begin
				s = earliest_slot(skip, TIME_MAX);
				if (s < 0) break;
				skip[s] = 1;
				armed[s] = 0;
				push_event(EV_STOPPED, s, 0);
				cnt++;
			end
			push_event(EV_DONE, 0, 31'(cnt));
		end
		default: push_event(EV_DONE, 0, 0);
		endcase
		pending_events[$].lst = 1;
	endtask

	always @(posedge clk) begin
		event_t e;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			events_seen <= events_seen + 1;
			if (pending_events.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10)
					$display("unexpected event kind=%0d slot=%0d value=%0d",
						event_kind, timer_slot, value);
			end else begin
				e = pending_events.pop_front();
				if (e.kind !== event_kind || e.tslot !== timer_slot || e.val !== value
						|| e.lst !== last) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch exp k=%0d s=%0d v=%0d l=%0d got k=%0d s=%0d v=%0d l=%0d",
							e.kind, e.tslot, e.val, e.lst,
							event_kind, timer_slot, value, last);
				end
			end
		end
		if (arst_n) out_stall <= calm ? 1'b0 : ($urandom_range(99) < 15);
	end

	task automatic write_empty_wait(logic [30:0] v);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= {1'b0, v};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		empty_wait_m = v;
	endtask

	task automatic send_request(logic [2:0] cmd, logic [47:0] t, logic [31:0] tmo,
			logic [31:0] rep, logic [3:0] sl);
		@(posedge clk);
		while (!calm && $urandom_range(99) < 15) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		command <= cmd; now <= t; timeout <= tmo; repeat_req <= rep; slot <= sl;
		do @(posedge clk); while (in_stall);
		predict_timers(cmd, t, tmo, rep, sl);
		requests_sent++;
		in_valid <= 0;
	endtask

	task automatic drain_events();
		while (pending_events.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin : timeout_watch
		wait (cycles > 1500000);
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		row_t plan[$];
		row_t r;
		event_t hd;
		logic [2:0] c;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1;

		// typed rows on an empty table: expected result read straight off
		plan.push_back('{CMD_NEAREST, 48'd0, 0, 0, 0, 1, EV_NEAREST, 31'd1000});
		plan.push_back('{CMD_RUN, TIME_MAX, 0, 0, 0, 1, EV_DONE, 31'd0});
		plan.push_back('{CMD_STOP_ALL, 48'd5, 0, 0, 0, 1, EV_DONE, 31'd0});
		plan.push_back('{CMD_CLEAR, 48'd5, 0, 0, 4'd15, 1, EV_CLEAR_MISS, 31'd0});
		plan.push_back('{3'd5, 48'd5, 0, 0, 0, 1, EV_DONE, 31'd0});
		plan.push_back('{3'd7, 48'd5, 0, 0, 0, 1, EV_DONE, 31'd0});
		// predicted rows: saturation, periodic, a batch of ten adds, order
		plan.push_back('{CMD_ADD, TIME_MAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0});
		plan.push_back('{CMD_ADD, 48'd0, 32'hFFFF_FFFF, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_NEAREST, 48'd0, 0, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_ADD, 48'd10, 0, 32'd3, 0, 0, 0, 0});
		plan.push_back('{CMD_ADD, 48'd10, 32'd5, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_RUN, 48'd20, 0, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_RUN, 48'd20, 0, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_NEAREST, 48'd100, 0, 0, 0, 0, 0, 0});
		for (int i = 0; i < 10; i++)
			plan.push_back('{CMD_ADD, 48'd1, 32'd2, 32'd0, 0, 0, 0, 0});
		plan.push_back('{CMD_RUN, TIME_MAX, 0, 0, 0, 0, 0, 0});
		plan.push_back('{CMD_CLEAR, 48'd1, 0, 0, 4'd0, 0, 0, 0});
		plan.push_back('{CMD_STOP_ALL, 48'd1, 0, 0, 0, 0, 0, 0});

		foreach (plan[i]) begin
			r = plan[i];
			send_request(r.cmd, r.tnow, r.tmo, r.rep, r.sl);
			if (r.typed) begin
				hd = pending_events[$];
				if (hd.kind !== r.xkind || hd.val !== r.xvalue) begin
					mismatches++;
					$display("table row %0d predicts k=%0d v=%0d", i, hd.kind, hd.val);
				end
			end
		end
		drain_events();

		write_empty_wait(31'd0);
		send_request(CMD_NEAREST, 48'd0, 0, 0, 0);
		drain_events();
		write_empty_wait(WAIT_MAX);
		send_request(CMD_NEAREST, 48'd0, 0, 0, 0);
		drain_events();
		write_empty_wait(31'($urandom));

		for (int n = 0; n < 350; n++) begin
			calm = (n >= 150 && n < 200);
			if (n == 250) begin
				drain_events();
				write_empty_wait(31'd1000);
			end
			pick = $urandom_range(99);
			clock_ms = clock_ms + 48'($urandom_range(40));
			if (pick < 2) clock_ms = 48'({$urandom, $urandom});
			c = pick < 40 ? CMD_ADD : pick < 55 ? CMD_CLEAR : pick < 80 ? CMD_RUN :
				pick < 92 ? CMD_NEAREST : pick < 97 ? CMD_STOP_ALL : 3'($urandom_range(5, 7));
			send_request(c, clock_ms,
				($urandom_range(9) == 0) ? $urandom : $urandom_range(60),
				($urandom_range(3) == 0) ? 0 :
				($urandom_range(9) == 0) ? $urandom : $urandom_range(30),
				4'($urandom));
		end
		calm = 0;
		drain_events();

		$display("ran %0d timer requests and checked %0d events over %0d cycles",
			requests_sent, events_seen, cycles);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("status: fail");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/ttab_pkg.sv
hdl/ttab_regs.sv
hdl/ttab_ctrl.sv
hdl/ttab_dp.sv
hdl/timer_table_engine.sv
hdl/ttab_checker.sv
sim/tb_timer_table_engine.sv
